>>> rtl/websocket_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared property wrappers for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parse phases, event and error codes, opcodes and the result type.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Parse phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Event kinds
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_RSV     = 2'd1;
  localparam logic [1:0] ERR_OPCODE  = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG = 2'd3;

  // Frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd8388608;

  // One result item plus its valid flag
  typedef struct packed {
    logic        vld;
    logic [1:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        last_of_frame;
    logic [31:0] frame_length;
    logic [1:0]  err_code;
  } res_t;

endpackage

>>> rtl/wsd_in_if.sv
// ----------------------------------------------------------------------------
// WebSocket deframer input channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

>>> rtl/wsd_out_if.sv
// ----------------------------------------------------------------------------
// WebSocket deframer result channel
// Valid/ready channel carrying one parser event per item.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        final_fragment;
  logic        last_of_frame;
  logic [31:0] frame_length;
  logic [1:0]  err_code;

  modport source (output valid, output event_kind, output payload_byte, output frame_opcode,
                  output final_fragment, output last_of_frame, output frame_length,
                  output err_code, input ready);
  modport sink   (input valid, input event_kind, input payload_byte, input frame_opcode,
                  input final_fragment, input last_of_frame, input frame_length,
                  input err_code, output ready);
  modport mon    (input valid, input event_kind, input payload_byte, input frame_opcode,
                  input final_fragment, input last_of_frame, input frame_length,
                  input err_code, input ready);
endinterface

>>> rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Frame header state machine, length check and payload unmasking; one byte
// per cycle when the result stage can advance.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        proc,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] max_len,
  output res_t        res
);

  logic [2:0]  phase_r,  phase_nxt;
  logic        fin_r,    fin_nxt;
  logic [2:0]  rsv_r,    rsv_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r,   mask_nxt;
  logic [63:0] len_r,    len_nxt;
  logic [3:0]  left_r,   left_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [31:0] pos_r,    pos_nxt;
  logic        halted_r, halted_nxt;

  logic        al_go;
  logic        hd_go;
  logic [63:0] len_cand;
  logic [31:0] pos_inc;
  logic        last;
  logic [7:0]  key_byte;

  // Select the key byte for the current payload position
  always_comb begin
    case (pos_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Payload length is below 2^32 here, so a 32-bit compare is exact
  assign pos_inc = pos_r + 32'd1;
  assign last    = (pos_inc >= len_r[31:0]);

  // Next state and result for one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    rsv_nxt    = rsv_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    al_go      = 1'b0;
    hd_go      = 1'b0;
    len_cand   = len_r;

    res                = '0;
    res.frame_opcode   = opcode_r;
    res.final_fragment = fin_r;

    if (proc && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt    = rx_byte[7];
          rsv_nxt    = rx_byte[6:4];
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = rx_byte[7];
          if (rsv_r != 3'd0) begin
            res.vld           = 1'b1;
            res.event_kind    = EV_ERROR;
            res.last_of_frame = 1'b1;
            res.err_code      = ERR_RSV;
            halted_nxt        = 1'b1;
          end else if (!(opcode_r inside {OP_CONT, OP_TEXT, OP_BIN,
                                          OP_CLOSE, OP_PING, OP_PONG})) begin
            res.vld           = 1'b1;
            res.event_kind    = EV_ERROR;
            res.last_of_frame = 1'b1;
            res.err_code      = ERR_OPCODE;
            halted_nxt        = 1'b1;
          end else if (rx_byte[6:0] == LEN7_EXT16 || rx_byte[6:0] == LEN7_EXT64) begin
            len_nxt   = '0;
            left_nxt  = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_nxt  = {57'd0, rx_byte[6:0]};
            len_cand = len_nxt;
            al_go    = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_nxt  = {len_r[55:0], rx_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            len_cand = len_nxt;
            al_go    = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], rx_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            hd_go = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_inc;
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          if (opcode_r == OP_CLOSE) begin
            // Swallow close payload, report the close on its last byte
            if (last) begin
              res.vld           = 1'b1;
              res.event_kind    = EV_CLOSE;
              res.last_of_frame = 1'b1;
              res.frame_length  = len_r[31:0];
              halted_nxt        = 1'b1;
            end
          end else begin
            res.vld           = 1'b1;
            res.event_kind    = EV_BYTE;
            res.payload_byte  = rx_byte ^ (mask_r ? key_byte : 8'd0);
            res.last_of_frame = last;
            res.frame_length  = len_r[31:0];
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // Length known: go collect the mask key or finish the header
      if (al_go) begin
        key_nxt = '0;
        if (mask_nxt) begin
          phase_nxt = PH_MASK;
          left_nxt  = KEY_BYTES;
        end else begin
          hd_go = 1'b1;
        end
      end

      // Header complete: check length, then start payload or close out
      if (hd_go) begin
        if (len_cand[63:32] != 32'd0 || len_cand[31:0] > max_len) begin
          res.vld           = 1'b1;
          res.event_kind    = EV_ERROR;
          res.last_of_frame = 1'b1;
          res.err_code      = ERR_TOO_BIG;
          halted_nxt        = 1'b1;
        end else begin
          pos_nxt = '0;
          if (len_cand == 64'd0) begin
            phase_nxt         = PH_HDR0;
            res.vld           = 1'b1;
            res.last_of_frame = 1'b1;
            if (opcode_r == OP_CLOSE) begin
              res.event_kind = EV_CLOSE;
              halted_nxt     = 1'b1;
            end else begin
              res.event_kind = EV_EMPTY;
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      rsv_r    <= 3'd0;
      opcode_r <= 4'd0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      left_r   <= 4'd0;
      key_r    <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      rsv_r    <= rsv_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> rtl/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result item for the output channel and tells the parser stage
// when it may advance.
// ----------------------------------------------------------------------------
module wsd_out_reg import wsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  res_t  res,
  output logic  adv,
  wsd_out_if.source out_chan
);

  logic valid_r, valid_nxt;
  res_t data_r;

  // Advance when the register is empty or its item is taken now
  assign adv       = !valid_r || out_chan.ready;
  assign valid_nxt = adv ? res.vld : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.event_kind     = data_r.event_kind;
  assign out_chan.payload_byte   = data_r.payload_byte;
  assign out_chan.frame_opcode   = data_r.frame_opcode;
  assign out_chan.final_fragment = data_r.final_fragment;
  assign out_chan.last_of_frame  = data_r.last_of_frame;
  assign out_chan.frame_length   = data_r.frame_length;
  assign out_chan.err_code       = data_r.err_code;

endmodule

>>> rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into unmasked payload bytes, empty-frame,
// close and error events.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+---------------------------------------
//   in_chan   | in  | valid/ready    | rx_byte
//   out_chan  | out | valid/ready    | event_kind .. err_code
//   cfg_*     | in  | cfg_wr_en only | max_payload_length (32 bits)
//
// One byte per cycle while the output register does not stall: input
// register, one pass of parser logic, result register; the result item of a
// byte shows on the output once the result register has taken it.
// The output register stalls the parser; the input register takes a new byte
// in the cycle the held one moves on. Synchronous active-low reset returns to
// the first header byte and sets the length limit to 8 MiB.
// After an error or close event all further bytes are taken and dropped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wsd_in_if.sink      in_chan,
  wsd_out_if.source   out_chan,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic [31:0] max_len_r;
  logic        adv;
  logic        proc;
  res_t        res;

  // Take a byte whenever the held one is gone or moves on
  assign in_chan.ready = !in_valid_r || adv;
  assign proc          = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (proc),
    .rx_byte (in_byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  wsd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .adv      (adv),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/wsd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level checks on result stalls, event consistency and halting.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_checker import wsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_kind,
  input logic [7:0]  out_payload_byte,
  input logic        out_last_of_frame,
  input logic [31:0] out_frame_length,
  input logic [1:0]  out_err_code
);

  logic        out_hold;
  logic        out_stop;
  logic        is_err;
  logic        has_code;
  logic [41:0] out_data;

  assign out_hold = out_valid && !out_ready;
  assign out_stop = out_valid && out_ready &&
                    (out_event_kind == EV_CLOSE || out_event_kind == EV_ERROR);
  assign is_err   = (out_event_kind == EV_ERROR);
  assign has_code = (out_err_code != ERR_NONE);
  assign out_data = {out_event_kind, out_payload_byte, out_frame_length};

  // A stalled result stays valid and keeps its kind, byte and length
  `WSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_data), "stalled result changed")

  // Every event other than a payload byte ends its frame
  `WSD_ASSERT(a_last_flag, clk, rst_n, !out_valid || out_event_kind == EV_BYTE || out_last_of_frame, "event without last flag")

  // Error code goes with error events only
  `WSD_ASSERT(a_err_code, clk, rst_n, !out_valid || (is_err == has_code), "error code does not match event")

  // Nothing follows a close or an error
  `WSD_ASSERT_NEXT(a_halt, clk, rst_n, out_stop, !out_valid, "result after close or error")

  // An empty result register never holds back the input
  `WSD_ASSERT(a_in_ready, clk, rst_n, out_valid || in_ready, "input blocked with empty output")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_event_kind    (out_chan.event_kind),
  .out_payload_byte  (out_chan.payload_byte),
  .out_last_of_frame (out_chan.last_of_frame),
  .out_frame_length  (out_chan.frame_length),
  .out_err_code      (out_chan.err_code)
);

>>> sim/tb_websocket_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends frame byte streams under several length limits, predicts every event
// in a local parser and compares each result item field by field. A run ends
// with one error or close frame followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // How a frame announces its payload length
  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_e;

  // Frames that stop the parser for the rest of the run
  typedef enum int {END_RSV, END_OPCODE, END_TOO_LONG, END_CLOSE_EMPTY, END_CLOSE_DATA} end_case_e;

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_4TH, RX_LONG_STALL} rx_mode_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  wsd_in_if  in_chan();
  wsd_out_if out_chan();

  websocket_frame_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Parser state as the block should hold it
  logic [2:0]  ph_q      = PH_HDR0;
  logic        fin_q     = 1'b0;
  logic [2:0]  rsv_q     = 3'd0;
  logic [3:0]  op_q      = 4'd0;
  logic        masked_q  = 1'b0;
  logic [63:0] len_q     = 64'd0;
  logic [3:0]  left_q    = 4'd0;
  logic [31:0] key_q     = 32'd0;
  logic [31:0] pos_q     = 32'd0;
  logic        stopped_q = 1'b0;
  logic [31:0] max_len_q = MAX_LEN_RESET;

  res_t pending_events[$];
  res_t want;
  res_t seen;
  int   fail_count = 0;
  int   bytes_sent = 0;
  int   burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------
  function automatic res_t make_event(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last, input logic [31:0] len,
                                      input logic [1:0] err);
    res_t ev;
    ev.vld            = 1'b1;
    ev.event_kind     = kind;
    ev.payload_byte   = data;
    ev.frame_opcode   = op_q;
    ev.final_fragment = fin_q;
    ev.last_of_frame  = last;
    ev.frame_length   = len;
    ev.err_code       = err;
    return ev;
  endfunction

  // Queue one predicted event behind the others
  task automatic add_event(input res_t ev);
    pending_events.insert(pending_events.size(), ev);
  endtask

  task automatic raise_error(input logic [1:0] err);
    add_event(make_event(EV_ERROR, 8'h00, 1'b1, 32'd0, err));
    stopped_q = 1'b1;
  endtask

  // Header complete: check the limit, then start payload or close out an empty frame
  task automatic close_header();
    if (len_q > {32'd0, max_len_q}) begin
      raise_error(ERR_TOO_BIG);
    end else begin
      pos_q = 32'd0;
      if (len_q == 64'd0) begin
        ph_q = PH_HDR0;
        if (op_q == OP_CLOSE) begin
          add_event(make_event(EV_CLOSE, 8'h00, 1'b1, 32'd0, ERR_NONE));
          stopped_q = 1'b1;
        end else begin
          add_event(make_event(EV_EMPTY, 8'h00, 1'b1, 32'd0, ERR_NONE));
        end
      end else begin
        ph_q = PH_PAYLOAD;
      end
    end
  endtask

  // Length known: collect the mask key next if there is one
  task automatic close_length();
    key_q = 32'd0;
    if (masked_q) begin
      ph_q   = PH_MASK;
      left_q = KEY_BYTES;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [1:0] sel;
    logic [7:0] key_byte;
    logic       last;
    if (!stopped_q) begin
      case (ph_q)
        PH_HDR0: begin
          fin_q = b[7];
          rsv_q = b[6:4];
          op_q  = b[3:0];
          ph_q  = PH_HDR1;
        end
        PH_HDR1: begin
          len7     = b[6:0];
          masked_q = b[7];
          if (rsv_q != 3'd0) begin
            raise_error(ERR_RSV);
          end else if (!(op_q == OP_CONT || op_q == OP_TEXT || op_q == OP_BIN ||
                         op_q == OP_CLOSE || op_q == OP_PING || op_q == OP_PONG)) begin
            raise_error(ERR_OPCODE);
          end else begin
            len_q = 64'd0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
              left_q = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
              ph_q   = PH_EXTLEN;
            end else begin
              len_q = {57'd0, len7};
              close_length();
            end
          end
        end
        PH_EXTLEN: begin
          len_q  = {len_q[55:0], b};
          left_q = left_q - 4'd1;
          if (left_q == 4'd0) close_length();
        end
        PH_MASK: begin
          key_q  = {key_q[23:0], b};
          left_q = left_q - 4'd1;
          if (left_q == 4'd0) close_header();
        end
        PH_PAYLOAD: begin
          sel      = 2'd3 - pos_q[1:0];
          key_byte = masked_q ? key_q[8*sel +: 8] : 8'h00;
          pos_q    = pos_q + 32'd1;
          last     = ({32'd0, pos_q} >= len_q);
          if (last) ph_q = PH_HDR0;
          if (op_q == OP_CLOSE) begin
            // Close payload is swallowed; only its last byte reports
            if (last) begin
              add_event(make_event(EV_CLOSE, 8'h00, 1'b1, len_q[31:0], ERR_NONE));
              stopped_q = 1'b1;
            end
          end else begin
            add_event(make_event(EV_BYTE, b ^ key_byte, last, len_q[31:0], ERR_NONE));
          end
        end
        default: ph_q = PH_HDR0;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one item; bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Hold the input idle until every expected event is out, then let the pipe settle
  task automatic drain(input int settle);
    int waited;
    in_chan.valid <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len_q = value;
  endtask

  task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input logic [63:0] len,
                             input len_form_e form, input logic [31:0] key);
    logic [6:0] len7;
    int         ext;
    int         i;
    if (form == LEN_SHORT && len < 64'd126) begin
      len7 = len[6:0];
      ext  = 0;
    end else if (form != LEN_64 && len < 64'd65536) begin
      len7 = LEN7_EXT16;
      ext  = 2;
    end else begin
      len7 = LEN7_EXT64;
      ext  = 8;
    end
    send_byte({fin, rsv, op});
    send_byte({masked, len7});
    for (i = ext - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked) begin
      for (i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input len_form_e form);
    longint i;
    send_header(fin, 3'd0, op, masked, len, form, $urandom);
    for (i = 0; i < longint'(len); i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Well-formed data or control frame, length no larger than cap
  task automatic send_random_frame(input logic [31:0] cap);
    logic [3:0]  op;
    logic [63:0] len;
    len_form_e   form;
    int          r;
    case ($urandom_range(0, 4))
      0: op = OP_CONT;
      1: op = OP_TEXT;
      2: op = OP_BIN;
      3: op = OP_PING;
      default: op = OP_PONG;
    endcase
    r = $urandom_range(0, 99);
    if (r < 15)      len = 64'd0;
    else if (r < 75) len = 64'($urandom_range(1, 12));
    else if (r < 92) len = 64'($urandom_range(13, 40));
    else             len = 64'($urandom_range(100, 300));
    if (len > {32'd0, cap}) len = 64'($urandom_range(0, cap));
    // Hit the limit exactly now and then
    if (cap < 32'd300 && $urandom_range(0, 3) == 0) len = {32'd0, cap};
    r = $urandom_range(0, 99);
    if (r < 70)      form = LEN_SHORT;
    else if (r < 85) form = LEN_16;
    else             form = LEN_64;
    send_frame(1'($urandom_range(0, 1)), op, $urandom_range(0, 3) != 0, len, form);
  endtask

  task automatic run_random_frames(input logic [31:0] cap, input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame(cap);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty frame, key order, 16 and 64 bit lengths, empty frame after a key
  task automatic test_directed();
    set_max_length(MAX_LEN_RESET);
    send_header(1'b1, 3'd0, OP_TEXT, 1'b0, 64'd0, LEN_SHORT, 32'h0);
    send_header(1'b1, 3'd0, OP_BIN, 1'b1, 64'd2, LEN_SHORT, 32'hA55A0FF0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(1'b0, 3'd0, OP_PONG, 1'b0, 64'd1, LEN_16, 32'h0);
    send_byte(8'h7F);
    send_header(1'b1, 3'd0, OP_CONT, 1'b0, 64'd1, LEN_64, 32'h0);
    send_byte(8'h80);
    send_header(1'b0, 3'd0, OP_PING, 1'b1, 64'd0, LEN_SHORT, 32'hFFFFFFFF);
  endtask

  // Limit of zero: only empty frames pass
  task automatic test_zero_limit();
    drain(4);
    set_max_length(32'd0);
    run_random_frames(32'd0, 60);
  endtask

  task automatic test_full_limit();
    drain(4);
    set_max_length(32'hFFFF_FFFF);
    run_random_frames(32'hFFFF_FFFF, 300);
  endtask

  // Small limit, frames up to and at the limit
  task automatic test_tight_limit();
    drain(4);
    set_max_length($urandom_range(1, 40));
    run_random_frames(max_len_q, 250);
  endtask

  task automatic test_default_limit();
    drain(4);
    set_max_length(MAX_LEN_RESET);
    run_random_frames(MAX_LEN_RESET, 350);
  endtask

  // One frame that stops the parser, then bytes that must be dropped
  task automatic test_terminal();
    end_case_e   pick;
    logic [3:0]  op;
    logic [63:0] len;
    drain(4);
    pick = end_case_e'($urandom_range(0, 4));
    case (pick)
      END_RSV: begin
        // Opcode may be bad too; reserved bits take precedence
        send_header(1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                    4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    64'($urandom_range(0, 125)), LEN_SHORT, $urandom);
      end
      END_OPCODE: begin
        op = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        send_header(1'($urandom_range(0, 1)), 3'd0, op, 1'($urandom_range(0, 1)),
                    64'($urandom_range(0, 125)), LEN_SHORT, $urandom);
      end
      END_TOO_LONG: begin
        op = ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_PING;
        if ($urandom_range(0, 1) != 0) begin
          set_max_length($urandom_range(0, 100));
          len = {32'd0, max_len_q} + 64'($urandom_range(1, 60));
          send_header(1'($urandom_range(0, 1)), 3'd0, op, 1'($urandom_range(0, 1)), len,
                      LEN_SHORT, $urandom);
        end else begin
          len = {32'($urandom_range(1, 255)), 32'($urandom)};
          send_header(1'($urandom_range(0, 1)), 3'd0, op, 1'($urandom_range(0, 1)), len,
                      LEN_64, $urandom);
        end
      end
      END_CLOSE_EMPTY: begin
        send_frame(1'($urandom_range(0, 1)), OP_CLOSE, 1'($urandom_range(0, 1)), 64'd0,
                   ($urandom_range(0, 1) != 0) ? LEN_SHORT : LEN_64);
      end
      default: begin
        send_frame(1'($urandom_range(0, 1)), OP_CLOSE, 1'($urandom_range(0, 1)),
                   64'($urandom_range(1, 10)), LEN_SHORT);
      end
    endcase
    repeat (30) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a changing pattern
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    rx_mode_e mode;
    int       span;
    int       k;
    out_chan.ready <= 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:      out_chan.ready <= 1'b1;
          RX_RANDOM:    out_chan.ready <= ($urandom_range(0, 2) != 0);
          RX_EVERY_4TH: out_chan.ready <= ((k % 4) != 3);
          default:      out_chan.ready <= ((k % 12) >= 8);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic log_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t %s: exp kind=%0d byte=%02h op=%0h fin=%0b last=%0b len=%0d err=%0d",
               $realtime, what, want.event_kind, want.payload_byte, want.frame_opcode,
               want.final_fragment, want.last_of_frame, want.frame_length, want.err_code);
      $display("%0t %s: got kind=%0d byte=%02h op=%0h fin=%0b last=%0b len=%0d err=%0d",
               $realtime, what, seen.event_kind, seen.payload_byte, seen.frame_opcode,
               seen.final_fragment, seen.last_of_frame, seen.frame_length, seen.err_code);
    end
    fail_count++;
  endtask

  // Compare each accepted result item with the oldest expected event
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.vld            = 1'b1;
      seen.event_kind     = out_chan.event_kind;
      seen.payload_byte   = out_chan.payload_byte;
      seen.frame_opcode   = out_chan.frame_opcode;
      seen.final_fragment = out_chan.final_fragment;
      seen.last_of_frame  = out_chan.last_of_frame;
      seen.frame_length   = out_chan.frame_length;
      seen.err_code       = out_chan.err_code;
      if (pending_events.size() == 0) begin
        want = '0;
        log_failure("unexpected event");
      end else begin
        want = pending_events.pop_front();
        if (seen.event_kind !== want.event_kind || seen.payload_byte !== want.payload_byte ||
            seen.frame_opcode !== want.frame_opcode ||
            seen.final_fragment !== want.final_fragment ||
            seen.last_of_frame !== want.last_of_frame ||
            seen.frame_length !== want.frame_length || seen.err_code !== want.err_code)
          log_failure("mismatch");
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.rx_byte <= 8'h00;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 32'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_limit();
    test_full_limit();
    test_tight_limit();
    test_default_limit();
    test_terminal();
    drain(8);

    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
